>>> rtl/thermocouple_j_linearizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Thermocouple J linearizer assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_J_LINEARIZER_UNIT_MACROS_SVH
`define THERMOCOUPLE_J_LINEARIZER_UNIT_MACROS_SVH

// same-cycle implication
`define TJL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TJL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tjl_pkg.sv
// ----------------------------------------------------------------------------
// Thermocouple J linearizer package
// Voltage table, field widths and the search pipeline item type.
// ----------------------------------------------------------------------------
package tjl_pkg;

    localparam int TABLE_POINTS       = 36;
    localparam int IDX_W              = 6;
    localparam int VOLT_W             = 16;
    localparam int DIFF_W             = VOLT_W + 1;
    localparam int TEMP_W             = 14;
    localparam int M_TDATA_W          = 24;
    localparam int BASE_W             = 14;
    localparam int ZERO_C_INDEX       = 5;
    localparam int TENTHS_PER_SEGMENT = 100;
    localparam int TEMP_MIN           = -8192;
    localparam int TEMP_MAX           = 8191;

    // type J table, -50 C to 300 C in 10 C steps, microvolts
    localparam logic signed [VOLT_W-1:0] VOLT_POINTS [TABLE_POINTS] = '{
        -16'sd2431, -16'sd1961, -16'sd1482, -16'sd995, -16'sd501,
        16'sd0,     16'sd507,   16'sd1019,  16'sd1537, 16'sd2059,
        16'sd2585,  16'sd3116,  16'sd3650,  16'sd4187, 16'sd4726,
        16'sd5269,  16'sd5814,  16'sd6360,  16'sd6909, 16'sd7459,
        16'sd8010,  16'sd8562,  16'sd9115,  16'sd9669, 16'sd10224,
        16'sd10779, 16'sd11334, 16'sd11889, 16'sd12445, 16'sd13000,
        16'sd13555, 16'sd14110, 16'sd14665, 16'sd15219, 16'sd15773,
        16'sd16327
    };

    typedef struct packed {
        logic signed [VOLT_W-1:0] volts;
        logic [IDX_W-1:0]         lo;
        logic [IDX_W-1:0]         hi;
    } srch_item_t;

endpackage

>>> rtl/tjl_search_step.sv
// ----------------------------------------------------------------------------
// Thermocouple J linearizer search step
// One registered bisection step of the segment search.
// ----------------------------------------------------------------------------
module tjl_search_step
    import tjl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  srch_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output srch_item_t out_item
);

    logic             valid_reg;
    srch_item_t       item_reg;
    srch_item_t       item_next;
    logic [IDX_W:0]   span_sum;
    logic [IDX_W-1:0] mid;

    always_comb
    begin
        span_sum  = {1'b0, in_item.lo} + {1'b0, in_item.hi};
        mid       = span_sum[IDX_W:1];
        item_next = in_item;
        // interval already down to one segment: pass through
        if ((in_item.hi - in_item.lo) > IDX_W'(1))
        begin
            if (VOLT_POINTS[mid] > in_item.volts)
                item_next.hi = mid;
            else
                item_next.lo = mid;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

>>> rtl/tjl_interp.sv
// ----------------------------------------------------------------------------
// Thermocouple J linearizer interpolator
// Four stages: offset and slope fetch, multiply, base add, truncate/saturate.
// ----------------------------------------------------------------------------
module tjl_interp
    import tjl_pkg::*;
#(
    parameter int NSEG      = 35,
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VOLT_W-1:0] in_volts,
    input  logic [IDX_W-1:0]         in_seg,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] out_temp,
    output logic [IDX_W-1:0]         out_seg
);

    // slope*10 < 0.25 for every segment, so F-1 bits hold the word
    localparam int SLOPE_W = FRAC_BITS - 1;
    localparam int PROD_W  = DIFF_W + SLOPE_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int Q_W     = SUM_W - FRAC_BITS;

    // slope ROM, words rounded to nearest at elaboration
    logic [SLOPE_W-1:0] slope_rom [NSEG];

    for (genvar g = 0; g < NSEG; g++)
    begin : g_slope
        localparam longint D    = longint'(VOLT_POINTS[g+1]) - longint'(VOLT_POINTS[g]);
        localparam longint NUM  = longint'(TENTHS_PER_SEGMENT) << FRAC_BITS;
        localparam longint WORD = (D == 0) ? 64'sd0 : (NUM + D / 2) / D;
        assign slope_rom[g] = SLOPE_W'(WORD);
    end

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic ready_a, ready_b, ready_c, ready_d;

    logic signed [DIFF_W-1:0] diff_a_reg, diff_a_next;
    logic [SLOPE_W-1:0]       slope_a_reg;
    logic [IDX_W-1:0]         seg_a_reg, seg_b_reg, seg_c_reg, seg_d_reg;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic signed [SUM_W-1:0]  sum_c_reg, sum_c_next;
    logic signed [TEMP_W-1:0] temp_d_reg, temp_d_next;

    logic signed [SLOPE_W:0]  slope_s;
    logic signed [BASE_W-1:0] base_tenths;
    logic signed [SUM_W-1:0]  base_full;
    logic signed [SUM_W-1:0]  adjusted;
    logic signed [Q_W-1:0]    quot;

    assign ready_d  = !vd_reg || out_ready;
    assign ready_c  = !vc_reg || ready_d;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        diff_a_next = DIFF_W'(in_volts) - DIFF_W'(VOLT_POINTS[in_seg]);

        slope_s     = $signed({1'b0, slope_a_reg});
        prod_b_next = diff_a_reg * slope_s;

        base_tenths = (BASE_W'(seg_b_reg) - BASE_W'(ZERO_C_INDEX))
                      * BASE_W'(TENTHS_PER_SEGMENT);
        base_full   = SUM_W'(base_tenths) <<< FRAC_BITS;
        sum_c_next  = SUM_W'(prod_b_reg) + base_full;

        // bias negative sums so the shift rounds toward zero
        if (sum_c_reg[SUM_W-1])
            adjusted = sum_c_reg + SUM_W'((longint'(1) << FRAC_BITS) - 1);
        else
            adjusted = sum_c_reg;
        quot = adjusted[SUM_W-1:FRAC_BITS];
        if (quot < Q_W'(TEMP_MIN))
            temp_d_next = TEMP_W'(TEMP_MIN);
        else if (quot > Q_W'(TEMP_MAX))
            temp_d_next = TEMP_W'(TEMP_MAX);
        else
            temp_d_next = quot[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                va_reg <= in_valid;
            if (ready_b)
                vb_reg <= va_reg;
            if (ready_c)
                vc_reg <= vb_reg;
            if (ready_d)
                vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            diff_a_reg  <= diff_a_next;
            slope_a_reg <= slope_rom[in_seg];
            seg_a_reg   <= in_seg;
        end
        if (va_reg && ready_b)
        begin
            prod_b_reg <= prod_b_next;
            seg_b_reg  <= seg_a_reg;
        end
        if (vb_reg && ready_c)
        begin
            sum_c_reg <= sum_c_next;
            seg_c_reg <= seg_b_reg;
        end
        if (vc_reg && ready_d)
        begin
            temp_d_reg <= temp_d_next;
            seg_d_reg  <= seg_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign out_temp  = temp_d_reg;
    assign out_seg   = seg_d_reg;

endmodule

>>> rtl/thermocouple_j_linearizer_unit.sv
// ----------------------------------------------------------------------------
// Thermocouple J linearizer
// Microvolt reading to tenths of a degree C by table search and interpolation.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per thermocouple reading, s_tdata = microvolts.
// Output stream m_*: one item per input item, in order, carrying the
// temperature in 0.1 C and the table segment used for it.
// Readings outside the table extrapolate on the first or last segment;
// the temperature saturates to the 14-bit range.
// Pipeline: $clog2(segments) bisection stages plus four interpolation stages,
// 10 register stages with the default table.
// Throughput: one item per cycle while m_tready is high; each stage holds
// one item and the bisection steps each cost one stage with a table compare.
// Reset clears every stage valid; no item is in flight afterward.
// When m_tready is low the items stay put and bubbles close up, so
// s_tready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
`include "thermocouple_j_linearizer_unit_macros.svh"

module thermocouple_j_linearizer_unit
    import tjl_pkg::*;
#(
    parameter int TABLE_SEGMENTS      = 35,
    parameter int SLOPE_FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VOLT_W-1:0]    s_tdata,   // [15:0] microvolts
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [13:0] temp_tenths, [19:14] segment_index
);

    localparam int NSEG   = (TABLE_SEGMENTS > TABLE_POINTS - 1) ? TABLE_POINTS - 1 :
                            (TABLE_SEGMENTS < 1) ? 1 : TABLE_SEGMENTS;
    localparam int NSTEPS = (NSEG > 1) ? $clog2(NSEG) : 1;

    srch_item_t               stage_item  [NSTEPS+1];
    logic                     stage_valid [NSTEPS+1];
    logic                     stage_ready [NSTEPS+1];
    logic signed [TEMP_W-1:0] temp_tenths;
    logic [IDX_W-1:0]         segment_index;

    assign stage_valid[0]      = s_tvalid;
    assign stage_item[0].volts = s_tdata;
    assign stage_item[0].lo    = '0;
    assign stage_item[0].hi    = IDX_W'(NSEG);
    assign s_tready            = stage_ready[0];

    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_step
        tjl_search_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    tjl_interp #(
        .NSEG      (NSEG),
        .FRAC_BITS (SLOPE_FRACTION_BITS)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NSTEPS]),
        .in_ready  (stage_ready[NSTEPS]),
        .in_volts  (stage_item[NSTEPS].volts),
        .in_seg    (stage_item[NSTEPS].lo),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_temp  (temp_tenths),
        .out_seg   (segment_index)
    );

    assign m_tdata = {{(M_TDATA_W - TEMP_W - IDX_W){1'b0}}, segment_index, temp_tenths};

    // search must have narrowed to a single segment
    `TJL_ASSERT_IMP(a_search_done, stage_valid[NSTEPS],
        stage_item[NSTEPS].hi == stage_item[NSTEPS].lo + IDX_W'(1), "search not converged")
    `TJL_ASSERT_IMP(a_seg_range, m_tvalid, segment_index < IDX_W'(NSEG),
        "segment index out of range")
    `TJL_ASSERT_IMP(a_empty_ready, !m_tvalid, s_tready, "input stalled with output empty")

endmodule
